[rtl/rgbc_pkg.sv]
// Shared types, register map and colour codes for the RGBC colour and line classifier.
// No dependencies.
`default_nettype none

package rgbc_pkg;

  localparam int unsigned CFG_AW = 5;
  localparam int unsigned DW = 16;

  localparam logic [2:0] REG_LINE   = 3'd0;
  localparam logic [2:0] REG_FLOOR  = 3'd1;
  localparam logic [2:0] REG_WRED   = 3'd2;
  localparam logic [2:0] REG_WGREEN = 3'd3;
  localparam logic [2:0] REG_WBLUE  = 3'd4;
  localparam logic [2:0] REG_MARGIN = 3'd5;

  localparam logic [DW-1:0] LINE_RST   = 16'd300;
  localparam logic [DW-1:0] FLOOR_RST  = 16'd1500;
  localparam logic [DW-1:0] WHITE_RST  = 16'd1000;
  localparam logic [DW-1:0] MARGIN_RST = 16'd3932;

  localparam logic [2:0] CLS_NONE  = 3'd0;
  localparam logic [2:0] CLS_RED   = 3'd1;
  localparam logic [2:0] CLS_GREEN = 3'd2;
  localparam logic [2:0] CLS_BLUE  = 3'd3;
  localparam logic [2:0] CLS_BLACK = 3'd4;

  localparam logic [13:0] LOW_TOTAL_SCALE = 14'd10000;
  localparam logic [6:0]  DARK_FULL       = 7'd100;

  typedef struct packed {
    logic [DW-1:0] line_threshold;
    logic [DW-1:0] floor_threshold;
    logic [DW-1:0] white_red;
    logic [DW-1:0] white_green;
    logic [DW-1:0] white_blue;
    logic [DW-1:0] dominance_margin;
  } cfg_t;

  // a zero white reference counts as one
  function automatic logic [DW-1:0] nz16(input logic [DW-1:0] w);
    return (w == '0) ? 16'd1 : w;
  endfunction

endpackage

`default_nettype wire

[rtl/rgbc_balance.sv]
// Colour path: white balancing by cross-multiplication, winner pick and margin test.
// Five register stages. Depends on rgbc_pkg.
`default_nettype none

module rgbc_balance (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire rgbc_pkg::cfg_t        cfg,
  input  wire logic                  in_valid,
  input  wire logic [15:0]           red,
  input  wire logic [15:0]           green,
  input  wire logic [15:0]           blue,
  input  wire logic [15:0]           clear,
  output logic                       out_valid,
  output logic [2:0]                 color
);

  logic [15:0] wr, wg, wb;
  logic [4:0]  vld_r;

  // stage 1
  logic        black1_r;
  logic [31:0] prg1_r, pgr1_r, pbr1_r, wrg1_r;
  // stage 2
  logic        black2_r;
  logic [47:0] rs2_r, gs2_r, bs2_r, w2_r;
  // stage 3
  logic        black3_r;
  logic [2:0]  color3_r;
  logic [49:0] t3_r;
  logic [47:0] top3_r, sec3_r, w3_r;
  logic [2:0]  color3_nxt;
  logic [47:0] top3_nxt, sec3_nxt;
  // stage 4
  logic        black4_r;
  logic [2:0]  color4_r;
  logic [63:0] t10k4_r;
  logic [65:0] mt4_r;
  logic [47:0] d4_r, w4_r;
  // stage 5
  logic [2:0]  color5_r;
  logic [2:0]  color5_nxt;

  assign wr = rgbc_pkg::nz16(cfg.white_red);
  assign wg = rgbc_pkg::nz16(cfg.white_green);
  assign wb = rgbc_pkg::nz16(cfg.white_blue);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[3:0], in_valid};
    end
  end

  always_comb begin
    if (rs2_r >= gs2_r && rs2_r >= bs2_r) begin
      color3_nxt = rgbc_pkg::CLS_RED;
      top3_nxt   = rs2_r;
      sec3_nxt   = (gs2_r > bs2_r) ? gs2_r : bs2_r;
    end else if (gs2_r >= bs2_r) begin
      color3_nxt = rgbc_pkg::CLS_GREEN;
      top3_nxt   = gs2_r;
      sec3_nxt   = (rs2_r > bs2_r) ? rs2_r : bs2_r;
    end else begin
      color3_nxt = rgbc_pkg::CLS_BLUE;
      top3_nxt   = bs2_r;
      sec3_nxt   = (rs2_r > gs2_r) ? rs2_r : gs2_r;
    end
  end

  always_comb begin
    if (black4_r) begin
      color5_nxt = rgbc_pkg::CLS_BLACK;
    end else if (t10k4_r < 64'(w4_r)) begin
      color5_nxt = rgbc_pkg::CLS_NONE;
    end else if (66'({d4_r, 16'd0}) < mt4_r) begin
      color5_nxt = rgbc_pkg::CLS_NONE;
    end else begin
      color5_nxt = color4_r;
    end
  end

  always_ff @(posedge clk) begin
    black1_r <= (clear <= cfg.line_threshold);
    prg1_r   <= 32'(red)   * 32'(wg);
    pgr1_r   <= 32'(green) * 32'(wr);
    pbr1_r   <= 32'(blue)  * 32'(wr);
    wrg1_r   <= 32'(wr)    * 32'(wg);

    black2_r <= black1_r;
    rs2_r    <= 48'(prg1_r) * 48'(wb);
    gs2_r    <= 48'(pgr1_r) * 48'(wb);
    bs2_r    <= 48'(pbr1_r) * 48'(wg);
    w2_r     <= 48'(wrg1_r) * 48'(wb);

    black3_r <= black2_r;
    t3_r     <= 50'(rs2_r) + 50'(gs2_r) + 50'(bs2_r);
    color3_r <= color3_nxt;
    top3_r   <= top3_nxt;
    sec3_r   <= sec3_nxt;
    w3_r     <= w2_r;

    black4_r <= black3_r;
    color4_r <= color3_r;
    t10k4_r  <= 64'(t3_r) * 64'(rgbc_pkg::LOW_TOTAL_SCALE);
    mt4_r    <= 66'(t3_r) * 66'(cfg.dominance_margin);
    d4_r     <= top3_r - sec3_r;
    w4_r     <= w3_r;

    color5_r <= color5_nxt;
  end

  assign out_valid = vld_r[4];
  assign color     = color5_r;

endmodule

`default_nettype wire

[rtl/rgbc_ramp.sv]
// Darkness path: line/floor tests and the ramp division, one or two quotient bits a stage.
// Five register stages. Depends on rgbc_pkg.
`default_nettype none

module rgbc_ramp (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire rgbc_pkg::cfg_t cfg,
  input  wire logic           in_valid,
  input  wire logic [15:0]    clear,
  output logic                out_valid,
  output logic                on_line,
  output logic [6:0]          darkness
);

  typedef struct packed {
    logic        q;
    logic [22:0] rem;
  } div_t;

  function automatic div_t div_step(input logic [22:0] rem, input logic [15:0] den,
                                    input int k);
    logic [22:0] dsh;
    div_t        res;
    dsh = 23'(den) << k;
    if (rem >= dsh) begin
      res.q   = 1'b1;
      res.rem = rem - dsh;
    end else begin
      res.q   = 1'b0;
      res.rem = rem;
    end
    return res;
  endfunction

  logic [4:0]  vld_r;
  logic [4:0]  line_r;
  logic [3:0]  zero_r;
  logic [15:0] den1_r, den2_r, den3_r, den4_r;
  logic [22:0] rem1_r, rem2_r, rem3_r, rem4_r;
  logic [1:0]  q2_r;
  logic [3:0]  q3_r;
  logic [5:0]  q4_r;
  logic [6:0]  dark5_r;
  div_t        s6, s5, s4, s3, s2, s1, s0;
  logic [6:0]  dark5_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[3:0], in_valid};
    end
  end

  always_comb begin
    s6 = div_step(rem1_r, den1_r, 6);
    s5 = div_step(s6.rem, den1_r, 5);
    s4 = div_step(rem2_r, den2_r, 4);
    s3 = div_step(s4.rem, den2_r, 3);
    s2 = div_step(rem3_r, den3_r, 2);
    s1 = div_step(s2.rem, den3_r, 1);
    s0 = div_step(rem4_r, den4_r, 0);
    if (line_r[3]) begin
      dark5_nxt = rgbc_pkg::DARK_FULL;
    end else if (zero_r[3]) begin
      dark5_nxt = '0;
    end else begin
      dark5_nxt = {q4_r, s0.q};
    end
  end

  always_ff @(posedge clk) begin
    line_r  <= {line_r[3:0], (clear <= cfg.line_threshold)};
    zero_r  <= {zero_r[2:0], (clear >= cfg.floor_threshold)};

    rem1_r  <= 23'(16'(cfg.floor_threshold - clear)) * 23'(rgbc_pkg::DARK_FULL);
    den1_r  <= cfg.floor_threshold - cfg.line_threshold;

    rem2_r  <= s5.rem;
    den2_r  <= den1_r;
    q2_r    <= {s6.q, s5.q};

    rem3_r  <= s3.rem;
    den3_r  <= den2_r;
    q3_r    <= {q2_r, s4.q, s3.q};

    rem4_r  <= s1.rem;
    den4_r  <= den3_r;
    q4_r    <= {q3_r, s2.q, s1.q};

    dark5_r <= dark5_nxt;
  end

  assign out_valid = vld_r[4];
  assign on_line   = line_r[4];
  assign darkness  = dark5_r;

endmodule

`default_nettype wire

[rtl/rgbc_color_and_line_classifier.sv]
// Top level of the RGBC colour and line classifier: register file, APB port, two datapaths.
// Depends on rgbc_pkg, rgbc_balance and rgbc_ramp.
//
// One item (a red, green, blue and clear sample) is taken on every cycle that start is
// high; busy never rises. Each result is on the out_ ports, marked by out_strobe, for the
// single cycle once its item has passed the register stages of both datapaths; results come in
// order and must be captured then, since the receiver cannot stall the block. The latency is
// set by the colour path: a 16 by 16 product, its product with the third white reference,
// the total and winner pick, the scaled products of the total, then the compares. The
// darkness divider is matched to it, resolving one or two quotient bits per stage. Registers
// are to be written only while no item is in flight.
`default_nettype none

module rgbc_color_and_line_classifier (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [15:0]                  in_red_count,
  input  wire logic [15:0]                  in_green_count,
  input  wire logic [15:0]                  in_blue_count,
  input  wire logic [15:0]                  in_clear_count,
  output logic                              out_strobe,
  output logic [2:0]                        out_color_code,
  output logic                              out_on_line,
  output logic [6:0]                        out_darkness,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [rgbc_pkg::CFG_AW-1:0]  paddr,
  input  wire logic [31:0]                  pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  rgbc_pkg::cfg_t cfg_r;
  logic           accept;
  logic           wr_en;
  logic [2:0]     reg_idx;
  logic           col_vld, dark_vld;

  assign busy    = 1'b0;
  assign pready  = 1'b1;
  assign accept  = start & ~busy;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.line_threshold   <= rgbc_pkg::LINE_RST;
      cfg_r.floor_threshold  <= rgbc_pkg::FLOOR_RST;
      cfg_r.white_red        <= rgbc_pkg::WHITE_RST;
      cfg_r.white_green      <= rgbc_pkg::WHITE_RST;
      cfg_r.white_blue       <= rgbc_pkg::WHITE_RST;
      cfg_r.dominance_margin <= rgbc_pkg::MARGIN_RST;
    end else if (wr_en) begin
      case (reg_idx)
        rgbc_pkg::REG_LINE:   cfg_r.line_threshold   <= pwdata[15:0];
        rgbc_pkg::REG_FLOOR:  cfg_r.floor_threshold  <= pwdata[15:0];
        rgbc_pkg::REG_WRED:   cfg_r.white_red        <= pwdata[15:0];
        rgbc_pkg::REG_WGREEN: cfg_r.white_green      <= pwdata[15:0];
        rgbc_pkg::REG_WBLUE:  cfg_r.white_blue       <= pwdata[15:0];
        rgbc_pkg::REG_MARGIN: cfg_r.dominance_margin <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      rgbc_pkg::REG_LINE:   prdata = 32'(cfg_r.line_threshold);
      rgbc_pkg::REG_FLOOR:  prdata = 32'(cfg_r.floor_threshold);
      rgbc_pkg::REG_WRED:   prdata = 32'(cfg_r.white_red);
      rgbc_pkg::REG_WGREEN: prdata = 32'(cfg_r.white_green);
      rgbc_pkg::REG_WBLUE:  prdata = 32'(cfg_r.white_blue);
      rgbc_pkg::REG_MARGIN: prdata = 32'(cfg_r.dominance_margin);
      default:              prdata = '0;
    endcase
  end

  rgbc_balance u_balance (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (accept),
    .red       (in_red_count),
    .green     (in_green_count),
    .blue      (in_blue_count),
    .clear     (in_clear_count),
    .out_valid (col_vld),
    .color     (out_color_code)
  );

  rgbc_ramp u_ramp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (accept),
    .clear     (in_clear_count),
    .out_valid (dark_vld),
    .on_line   (out_on_line),
    .darkness  (out_darkness)
  );

  assign out_strobe = col_vld & dark_vld;

endmodule

`default_nettype wire
